/* rtl/cgfs_pkg.sv */
// ----------------------------------------------------------------------------
// cgfs_pkg: shared types and constants of the coverage gap fill smoother
// Register indexes, command flags and back-end sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package cgfs_pkg;

  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 16;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_SMOOTHING = 3'd0,
    CFG_THINNING  = 3'd1,
    CFG_ALL_CHROM = 3'd2,
    CFG_TARGET    = 3'd3,
    CFG_OUTLIER   = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] OutlierReset = 16'd2000;
  localparam logic [16:0] QOne = 17'd65536;

  // per-record flags handed from the front end to the back end
  typedef struct packed {
    logic reset_avg;  // load the average from this record's coverage
    logic fill_en;    // gap filling allowed for this record
  } cgfs_flags_t;

  localparam int FlagsBits = $bits(cgfs_flags_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_MUL,
    S_ADD,
    S_SQR,
    S_ACC,
    S_FLUSH
  } back_state_e;

endpackage

`default_nettype wire

/* rtl/cgfs_if.sv */
// ----------------------------------------------------------------------------
// cgfs_if: record and sample channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cgfs_in_if #(
  parameter int POSITION_BITS = 32
);
  logic                     valid;
  logic                     ready;
  logic [7:0]               chrom_id;
  logic [POSITION_BITS-1:0] position;
  logic [15:0]              coverage;

  modport source (output valid, chrom_id, position, coverage, input ready);
  modport sink (input valid, chrom_id, position, coverage, output ready);
endinterface

interface cgfs_out_if #(
  parameter int POSITION_BITS = 32
);
  logic                     valid;
  logic                     ready;
  logic [7:0]               out_chrom;
  logic [POSITION_BITS-1:0] out_position;
  logic [15:0]              smoothed_k;
  logic                     is_spoofed;
  logic                     last;
  logic [31:0]              kept_count;
  logic [31:0]              spoofed_count;
  logic [63:0]              sum_coverage;
  logic [63:0]              sum_square;

  modport source (output valid, out_chrom, out_position, smoothed_k, is_spoofed, last,
                  kept_count, spoofed_count, sum_coverage, sum_square, input ready);
  modport sink (input valid, out_chrom, out_position, smoothed_k, is_spoofed, last,
                kept_count, spoofed_count, sum_coverage, sum_square, output ready);
endinterface

`default_nettype wire

/* rtl/cgfs_queue.sv */
// ----------------------------------------------------------------------------
// cgfs_queue: two-entry command queue
// Decouples the record front end from the sample back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cgfs_queue #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      data_o
);

  logic [W-1:0] mem_q [2];
  logic         wr_q, wr_d;
  logic         rd_q, rd_d;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/cgfs_front.sv */
// ----------------------------------------------------------------------------
// cgfs_front: record classification
// Tracks chromosome, step and previous position; queues active records.
// ----------------------------------------------------------------------------
`default_nettype none

module cgfs_front #(
  parameter int PB = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       chrom_i,
  input  wire logic [PB-1:0]    pos_i,
  input  wire logic             all_chrom_i,
  input  wire logic [7:0]       target_i,
  output logic                  push_o,
  output cgfs_pkg::cgfs_flags_t flags_o,
  output logic [PB-1:0]         prev_o,
  output logic [PB-1:0]         step_o
);

  logic [1:0]    rc_q, rc_d;
  logic [7:0]    chrom_q, chrom_d;
  logic          act_q, act_d;
  logic [PB-1:0] prev_q, prev_d;
  logic [PB-1:0] step_q, step_d;

  logic          acc, chg;
  logic [PB-1:0] prev1, step1, diff;

  always_comb begin
    acc   = all_chrom_i || (chrom_i == target_i);
    chg   = (rc_q != 2'd0) && (chrom_i != chrom_q);
    prev1 = prev_q;
    act_d = act_q;
    if (rc_q == 2'd0) begin
      prev1 = pos_i;
      if (acc) begin
        act_d = 1'b1;
      end
    end else if (chg) begin
      prev1 = pos_i - step_q;
      act_d = acc;
    end
    diff  = pos_i - prev1;
    step1 = ((rc_q == 2'd1) && (pos_i >= prev1)) ? diff : step_q;
    step_d = step1;
    flags_o.fill_en = 1'b0;
    if (act_d && (rc_q == 2'd2)) begin
      if ((pos_i >= prev1) && (diff < step1)) begin
        step_d = diff;
      end
      flags_o.fill_en = (step_d != '0);
    end
    flags_o.reset_avg = ((rc_q == 2'd0) && acc) || chg;
    chrom_d = (rc_q == 2'd0 || chg) ? chrom_i : chrom_q;
    prev_d  = act_d ? pos_i : prev1;
    rc_d    = (rc_q == 2'd2) ? rc_q : rc_q + 2'd1;
    push_o  = accept_i && act_d;
    prev_o  = prev1;
    step_o  = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q    <= 2'd0;
      chrom_q <= 8'd0;
      act_q   <= 1'b0;
      prev_q  <= '0;
      step_q  <= '0;
    end else if (accept_i) begin
      rc_q    <= rc_d;
      chrom_q <= chrom_d;
      act_q   <= act_d;
      prev_q  <= prev_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/cgfs_rem.sv */
// ----------------------------------------------------------------------------
// cgfs_rem: bit-serial remainder unit
// Restoring remainder of a position by the thinning step, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cgfs_rem #(
  parameter int PB = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [PB-1:0] dividend_i,
  input  wire logic [15:0]   divisor_i,
  output logic               done_o,
  output logic               zero_o
);

  localparam int CntBits = $clog2(PB + 1);

  logic [PB-1:0]      sh_q;
  logic [15:0]        rem_q;
  logic [15:0]        dvs_q;
  logic [CntBits-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [16:0]        trial;

  assign trial  = {rem_q, sh_q[PB-1]};
  assign done_o = done_q;
  assign zero_o = (rem_q == 16'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntBits'(PB);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i;
      rem_q <= 16'd0;
      dvs_q <= (divisor_i == 16'd0) ? 16'd1 : divisor_i;
    end else if (busy_q) begin
      sh_q  <= sh_q << 1;
      rem_q <= (trial >= {1'b0, dvs_q}) ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/cgfs_back.sv */
// ----------------------------------------------------------------------------
// cgfs_back: sample sequencer
// Expands a record into fill and real samples, smooths, thins and sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cgfs_back #(
  parameter int PB = 32,
  parameter int MAX_FILL = 63
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  input  wire cgfs_pkg::cgfs_flags_t q_flags_i,
  input  wire logic [7:0]        q_chrom_i,
  input  wire logic [PB-1:0]     q_pos_i,
  input  wire logic [15:0]       q_cov_i,
  input  wire logic [PB-1:0]     q_prev_i,
  input  wire logic [PB-1:0]     q_step_i,
  input  wire logic [15:0]       smooth_i,
  input  wire logic [15:0]       thin_i,
  input  wire logic [15:0]       limit_i,
  cgfs_out_if.source             out
);

  localparam int FcBits = $clog2(MAX_FILL + 1);

  cgfs_pkg::back_state_e state_q, state_d;

  cgfs_pkg::cgfs_flags_t flags_q;
  logic [7:0]        chrom_q;
  logic [PB-1:0]     pos_q, fprev_q, step_q, s_pos_q;
  logic [15:0]       c_q, s_cov_q, k_q;
  logic              s_spoof_q, real_q;
  logic [FcBits-1:0] fcnt_q;
  logic [31:0]       avg_q, avg_eff;
  logic [47:0]       p1_q;
  logic [32:0]       p2_q;
  logic [63:0]       sq_q;
  logic [31:0]       kept_q, spf_q;
  logic [63:0]       cacc_q, sacc_q;

  logic              pend_v_q;
  logic [7:0]        pend_chrom_q;
  logic [PB-1:0]     pend_pos_q;
  logic [15:0]       pend_k_q;
  logic              pend_spoof_q;
  logic [31:0]       pend_kept_q, pend_spf_q;
  logic [63:0]       pend_cacc_q, pend_sacc_q;

  logic        out_free, div_done, div_zero, div_start;
  logic        take, move, flush, fill_go;
  logic [PB:0] fsum;
  logic [49:0] avg_sum;
  logic [63:0] sq_rnd;
  logic [64:0] cacc_s, sacc_s;
  logic [31:0] kept_n, spf_n;
  logic [16:0] k_t;

  cgfs_rem #(.PB(PB)) u_rem (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (s_pos_q),
    .divisor_i  (thin_i),
    .done_o     (div_done),
    .zero_o     (div_zero)
  );

  assign out_free = !out.valid || out.ready;
  assign fsum     = {1'b0, fprev_q} + {1'b0, step_q};
  assign fill_go  = flags_q.fill_en && (fcnt_q < FcBits'(MAX_FILL)) && (fsum < {1'b0, pos_q});
  assign avg_eff  = q_flags_i.reset_avg ? {q_cov_i, 16'd0} : avg_q;
  assign avg_sum  = 50'(p1_q) + (50'(p2_q) << 16) + 50'd32768;
  assign k_t      = {1'b0, avg_q[31:16]} + 17'(avg_q[15]);
  assign sq_rnd   = (sq_q + 64'd32768) >> 16;
  assign cacc_s   = {1'b0, cacc_q} + 65'(avg_q);
  assign sacc_s   = {1'b0, sacc_q} + {1'b0, sq_rnd};
  assign kept_n   = (kept_q == '1) ? kept_q : kept_q + 32'd1;
  assign spf_n    = (s_spoof_q && spf_q != '1) ? spf_q + 32'd1 : spf_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cgfs_pkg::S_IDLE:  if (!q_empty_i) state_d = cgfs_pkg::S_CHK;
      cgfs_pkg::S_CHK:   state_d = cgfs_pkg::S_MUL;
      cgfs_pkg::S_MUL:   state_d = cgfs_pkg::S_ADD;
      cgfs_pkg::S_ADD:   state_d = cgfs_pkg::S_SQR;
      cgfs_pkg::S_SQR:   state_d = cgfs_pkg::S_ACC;
      cgfs_pkg::S_ACC: begin
        if (div_done && (!div_zero || !pend_v_q || out_free)) begin
          state_d = real_q ? cgfs_pkg::S_FLUSH : cgfs_pkg::S_CHK;
        end
      end
      cgfs_pkg::S_FLUSH: if (!pend_v_q || out_free) state_d = cgfs_pkg::S_IDLE;
      default:           state_d = cgfs_pkg::S_IDLE;
    endcase
  end

  // strobes
  always_comb begin
    q_pop_o   = (state_q == cgfs_pkg::S_IDLE) && !q_empty_i;
    div_start = (state_q == cgfs_pkg::S_MUL);
    take      = (state_q == cgfs_pkg::S_ACC) && div_done && div_zero &&
                (!pend_v_q || out_free);
    move      = take && pend_v_q;
    flush     = (state_q == cgfs_pkg::S_FLUSH) && pend_v_q && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cgfs_pkg::S_IDLE;
      avg_q    <= '0;
      kept_q   <= '0;
      spf_q    <= '0;
      cacc_q   <= '0;
      sacc_q   <= '0;
      fcnt_q   <= '0;
      pend_v_q <= 1'b0;
      out.valid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        avg_q  <= avg_eff;
        fcnt_q <= '0;
      end else if (state_q == cgfs_pkg::S_CHK && fill_go) begin
        fcnt_q <= fcnt_q + 1'b1;
      end else if (state_q == cgfs_pkg::S_ADD) begin
        avg_q <= avg_sum[47:16];
      end
      if (take) begin
        kept_q   <= kept_n;
        spf_q    <= spf_n;
        cacc_q   <= cacc_s[64] ? '1 : cacc_s[63:0];
        sacc_q   <= sacc_s[64] ? '1 : sacc_s[63:0];
        pend_v_q <= 1'b1;
      end else if (flush) begin
        pend_v_q <= 1'b0;
      end
      if (move || flush) begin
        out.valid <= 1'b1;
      end else if (out.ready) begin
        out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      flags_q <= q_flags_i;
      chrom_q <= q_chrom_i;
      pos_q   <= q_pos_i;
      fprev_q <= q_prev_i;
      step_q  <= q_step_i;
      // outlier coverage is replaced by the integer part of the average
      c_q     <= (q_cov_i > limit_i) ? avg_eff[31:16] : q_cov_i;
    end
    if (state_q == cgfs_pkg::S_CHK) begin
      if (fill_go) begin
        fprev_q   <= fsum[PB-1:0];
        s_pos_q   <= fsum[PB-1:0];
        s_cov_q   <= 16'd0;
        s_spoof_q <= 1'b1;
        real_q    <= 1'b0;
      end else begin
        s_pos_q   <= pos_q;
        s_cov_q   <= c_q;
        s_spoof_q <= 1'b0;
        real_q    <= 1'b1;
      end
    end
    if (state_q == cgfs_pkg::S_MUL) begin
      p1_q <= smooth_i * avg_q;
      p2_q <= (cgfs_pkg::QOne - {1'b0, smooth_i}) * s_cov_q;
    end
    if (state_q == cgfs_pkg::S_SQR) begin
      sq_q <= avg_q * avg_q;
      k_q  <= k_t[16] ? 16'hFFFF : k_t[15:0];
    end
    if (take) begin
      pend_chrom_q <= chrom_q;
      pend_pos_q   <= s_pos_q;
      pend_k_q     <= k_q;
      pend_spoof_q <= s_spoof_q;
      pend_kept_q  <= kept_n;
      pend_spf_q   <= spf_n;
      pend_cacc_q  <= cacc_s[64] ? '1 : cacc_s[63:0];
      pend_sacc_q  <= sacc_s[64] ? '1 : sacc_s[63:0];
    end
    if (move || flush) begin
      out.out_chrom     <= pend_chrom_q;
      out.out_position  <= pend_pos_q;
      out.smoothed_k    <= pend_k_q;
      out.is_spoofed    <= pend_spoof_q;
      out.last          <= flush;
      out.kept_count    <= pend_kept_q;
      out.spoofed_count <= pend_spf_q;
      out.sum_coverage  <= pend_cacc_q;
      out.sum_square    <= pend_sacc_q;
    end
  end

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= FcBits'(MAX_FILL))
    else $error("fill count beyond cap");

  a_acc_after_sqr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cgfs_pkg::S_SQR |=> state_q == cgfs_pkg::S_ACC)
    else $error("sequencer skipped accumulate");

  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> out.valid && out.last)
    else $error("record end not marked");

endmodule

`default_nettype wire

/* rtl/coverage_gap_fill_smoother.sv */
// ----------------------------------------------------------------------------
// coverage_gap_fill_smoother: streaming read-coverage smoother
// Records in (chrom_id, position, coverage); smoothed, gap-filled samples out.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries one record per beat. The front end classifies it against
//    the chromosome filter and step tracker and queues it (two entries).
//  - out_ch carries one sample per beat; last marks the final sample of a
//    record. Records that are filtered out or thinned away give no beats.
//  - cfg_we_i/cfg_idx_i/cfg_data_i write a register (index per cgfs_pkg),
//    only while the block is idle.
//  - Each sample (fill or real) passes the check, multiply, add, square and
//    accumulate states and waits in accumulate for the bit-serial thinning
//    remainder unit; a record is loaded in idle and ends with a flush.
//  - A kept fill waits until the next kept sample or the record end.
//  - Reset clears the step tracker, the average and all sums; registers take
//    their defaults (outlier limit 2000, thinning 1, all chromosomes).
//  - When out_ch stalls, one sample waits in the output register and one in
//    a hold stage; the sequencer then stops and the queue backs up to in_ch.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_gap_fill_smoother #(
  parameter int MAX_FILL = 63,
  parameter int POSITION_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  cgfs_in_if.sink                                in_ch,
  cgfs_out_if.source                             out_ch,
  input  wire logic                              cfg_we_i,
  input  wire logic [cgfs_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  wire logic [cgfs_pkg::CfgDataBits-1:0]  cfg_data_i
);

  localparam int PB = POSITION_BITS;
  // command word: flags, chrom, pos, coverage, prev, step
  localparam int CmdW = cgfs_pkg::FlagsBits + 8 + 16 + 3 * PB;

  // configuration registers
  logic [15:0] smooth_q, thin_q, limit_q;
  logic        all_q;
  logic [7:0]  target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= 16'd0;
      thin_q   <= 16'd1;
      all_q    <= 1'b1;
      target_q <= 8'd0;
      limit_q  <= cgfs_pkg::OutlierReset;
    end else if (cfg_we_i) begin
      unique case (cgfs_pkg::cfg_idx_e'(cfg_idx_i))
        cgfs_pkg::CFG_SMOOTHING: smooth_q <= cfg_data_i;
        cgfs_pkg::CFG_THINNING:  thin_q   <= cfg_data_i;
        cgfs_pkg::CFG_ALL_CHROM: all_q    <= cfg_data_i[0];
        cgfs_pkg::CFG_TARGET:    target_q <= cfg_data_i[7:0];
        cgfs_pkg::CFG_OUTLIER:   limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                  q_full, q_empty, q_pop, push;
  cgfs_pkg::cgfs_flags_t f_flags, b_flags;
  logic [PB-1:0]         f_prev, f_step, b_pos, b_prev, b_step;
  logic [7:0]            b_chrom;
  logic [15:0]           b_cov;
  logic [CmdW-1:0]       q_wdata, q_rdata;
  logic                  accept;

  // records are taken whenever the queue has room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  cgfs_front #(.PB(PB)) u_front (
    .clk_i,
    .rst_ni,
    .accept_i    (accept),
    .chrom_i     (in_ch.chrom_id),
    .pos_i       (in_ch.position),
    .all_chrom_i (all_q),
    .target_i    (target_q),
    .push_o      (push),
    .flags_o     (f_flags),
    .prev_o      (f_prev),
    .step_o      (f_step)
  );

  assign q_wdata = {f_flags, in_ch.chrom_id, in_ch.position, in_ch.coverage, f_prev, f_step};
  assign {b_flags, b_chrom, b_pos, b_cov, b_prev, b_step} = q_rdata;

  cgfs_queue #(.W(CmdW)) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  cgfs_back #(.PB(PB), .MAX_FILL(MAX_FILL)) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_flags_i (b_flags),
    .q_chrom_i (b_chrom),
    .q_pos_i   (b_pos),
    .q_cov_i   (b_cov),
    .q_prev_i  (b_prev),
    .q_step_i  (b_step),
    .smooth_i  (smooth_q),
    .thin_i    (thin_q),
    .limit_i   (limit_q),
    .out       (out_ch)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("command queue underflow");

  a_accept_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> accept)
    else $error("command queued without a record beat");

endmodule

`default_nettype wire
